### rtl/etok_pkg.sv
// ----------------------------------------------------------------------------
// etok_pkg
// Types and constants shared by the expression tokenizer modules.
// ----------------------------------------------------------------------------
package etok_pkg;

    // token kinds
    localparam logic [3:0] KIND_UNKNOWN  = 4'd0;
    localparam logic [3:0] KIND_NUMBER   = 4'd1;
    localparam logic [3:0] KIND_VARIABLE = 4'd2;
    localparam logic [3:0] KIND_PLUS     = 4'd3;
    localparam logic [3:0] KIND_MINUS    = 4'd4;
    localparam logic [3:0] KIND_TIMES    = 4'd5;
    localparam logic [3:0] KIND_DIVIDE   = 4'd6;
    localparam logic [3:0] KIND_LPAREN   = 4'd7;
    localparam logic [3:0] KIND_RPAREN   = 4'd8;
    localparam logic [3:0] KIND_SIN      = 4'd9;
    localparam logic [3:0] KIND_COS      = 4'd10;
    localparam logic [3:0] KIND_TAN      = 4'd11;

    localparam int MAX_WORD_LEN = 19;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;

    typedef struct packed {
        logic        sat;
        logic [4:0]  letter;
        logic [30:0] value;
        logic [3:0]  kind;
        logic        last;
    } token_t;

    // one or two tokens handed from the lexer to the output buffer
    typedef struct packed {
        logic   push;
        logic   two;
        token_t t1;
        token_t t0;
    } etok_push_t;

endpackage

### rtl/etok_lexer.sv
// ----------------------------------------------------------------------------
// etok_lexer
// Input register, lexer state and token generation: one character a cycle while push_ok allows.
// ----------------------------------------------------------------------------
module etok_lexer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [etok_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] ch
    input  logic                          s_tlast,   // end_of_text
    input  logic                          push_ok,
    output etok_pkg::etok_push_t          push_out
);
    import etok_pkg::*;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_NUM  = 2'd1;
    localparam logic [1:0] MODE_WORD = 2'd2;

    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_Z      = 8'h7A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    localparam logic [30:0] NUM_MAX  = 31'h7FFF_FFFF;
    localparam logic [4:0]  LEN_MAX  = 5'd31;

    // letters minus 'a', first letter in the low bits
    localparam logic [14:0] WORD_SIN = {5'd13, 5'd8,  5'd18};
    localparam logic [14:0] WORD_COS = {5'd18, 5'd14, 5'd2};
    localparam logic [14:0] WORD_TAN = {5'd13, 5'd0,  5'd19};

    logic        in_valid_reg;
    logic [7:0]  ch_reg;
    logic        eot_reg;

    logic [1:0]  mode_reg,    mode_next;
    logic [30:0] acc_reg,     acc_next;
    logic        clamp_reg,   clamp_next;
    logic [14:0] letters_reg, letters_next;
    logic [4:0]  len_reg,     len_next;

    logic        is_digit, is_letter, cont_num, cont_word;
    logic [3:0]  digit_val;
    logic [4:0]  letter_val;
    logic [34:0] acc_mul;
    logic        acc_over;
    logic [30:0] acc_add;
    logic        op_valid;
    logic [3:0]  op_kind;
    logic        pend_valid, fin_valid;
    token_t      pend_tok, op_tok, fin_tok;
    logic [1:0]  mode_step;
    logic [30:0] acc_step;
    logic        clamp_step;
    logic [14:0] letters_step;
    logic [4:0]  len_step;
    logic        consume;
    token_t      t0, t1;
    logic        n_any, n_two;

    function automatic token_t flush_tok(input logic [1:0] mode, input logic [30:0] acc,
                                         input logic clamp, input logic [14:0] lt,
                                         input logic [4:0] len);
        token_t t;
        t = '0;
        case (mode)
            MODE_NUM: begin
                t.kind  = KIND_NUMBER;
                t.value = acc;
                t.sat   = clamp;
            end
            MODE_WORD: begin
                if (len == 5'd1) begin
                    t.kind   = KIND_VARIABLE;
                    t.letter = lt[4:0];
                end else if (len == 5'd3 && MAX_WORD_LEN >= 3) begin
                    if (lt == WORD_SIN) begin
                        t.kind = KIND_SIN;
                    end else if (lt == WORD_COS) begin
                        t.kind = KIND_COS;
                    end else if (lt == WORD_TAN) begin
                        t.kind = KIND_TAN;
                    end
                end
            end
            default: ;
        endcase
        return t;
    endfunction

    assign is_digit   = ch_reg >= CH_0 && ch_reg <= CH_9;
    assign is_letter  = ch_reg >= CH_A && ch_reg <= CH_Z;
    assign digit_val  = 4'(ch_reg - CH_0);
    assign letter_val = 5'(ch_reg - CH_A);
    assign cont_num   = mode_reg == MODE_NUM && is_digit;
    assign cont_word  = mode_reg == MODE_WORD && is_letter;

    // acc * 10 + digit, clamp on overflow
    assign acc_mul  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {31'd0, digit_val};
    assign acc_over = acc_mul > {4'd0, NUM_MAX};
    assign acc_add  = (clamp_reg || acc_over) ? NUM_MAX : acc_mul[30:0];

    always_comb begin
        op_valid = 1'b1;
        op_kind  = KIND_UNKNOWN;
        case (ch_reg)
            CH_PLUS:   op_kind = KIND_PLUS;
            CH_MINUS:  op_kind = KIND_MINUS;
            CH_STAR:   op_kind = KIND_TIMES;
            CH_SLASH:  op_kind = KIND_DIVIDE;
            CH_LPAREN: op_kind = KIND_LPAREN;
            CH_RPAREN: op_kind = KIND_RPAREN;
            default:   op_valid = 1'b0;
        endcase
    end

    always_comb begin
        mode_step    = MODE_IDLE;
        acc_step     = '0;
        clamp_step   = 1'b0;
        letters_step = '0;
        len_step     = '0;
        if (cont_num) begin
            mode_step  = MODE_NUM;
            acc_step   = acc_add;
            clamp_step = clamp_reg || acc_over;
        end else if (cont_word) begin
            mode_step    = MODE_WORD;
            acc_step     = acc_reg;
            clamp_step   = clamp_reg;
            letters_step = letters_reg;
            case (len_reg)
                5'd0:    letters_step[4:0]   = letter_val;
                5'd1:    letters_step[9:5]   = letter_val;
                5'd2:    letters_step[14:10] = letter_val;
                default: ;
            endcase
            len_step = (len_reg < LEN_MAX) ? len_reg + 5'd1 : len_reg;
        end else if (is_digit) begin
            mode_step = MODE_NUM;
            acc_step  = {27'd0, digit_val};
        end else if (is_letter) begin
            mode_step         = MODE_WORD;
            letters_step[4:0] = letter_val;
            len_step          = 5'd1;
        end
    end

    // emission order: pending token, operator, end-of-text flush
    assign pend_valid = !cont_num && !cont_word &&
                        (mode_reg == MODE_NUM || mode_reg == MODE_WORD);
    assign pend_tok   = flush_tok(mode_reg, acc_reg, clamp_reg, letters_reg, len_reg);
    assign fin_valid  = eot_reg && (mode_step == MODE_NUM || mode_step == MODE_WORD);
    assign fin_tok    = flush_tok(mode_step, acc_step, clamp_step, letters_step, len_step);

    always_comb begin
        op_tok      = '0;
        op_tok.kind = op_kind;
    end

    // operator and end flush never both occur
    assign n_any = pend_valid || op_valid || fin_valid;
    assign n_two = pend_valid && (op_valid || fin_valid);

    always_comb begin
        t1      = op_valid ? op_tok : fin_tok;
        t1.last = 1'b1;
        t0      = pend_valid ? pend_tok : t1;
        t0.last = !n_two;
    end

    assign consume  = in_valid_reg && (!n_any || push_ok);
    assign s_tready = !in_valid_reg || consume;

    always_comb begin
        push_out.push = consume && n_any;
        push_out.two  = n_two;
        push_out.t0   = t0;
        push_out.t1   = t1;
    end

    always_comb begin
        if (eot_reg) begin
            mode_next    = MODE_IDLE;
            acc_next     = '0;
            clamp_next   = 1'b0;
            letters_next = '0;
            len_next     = '0;
        end else begin
            mode_next    = mode_step;
            acc_next     = acc_step;
            clamp_next   = clamp_step;
            letters_next = letters_step;
            len_next     = len_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            ch_reg  <= s_tdata;
            eot_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            acc_reg     <= '0;
            clamp_reg   <= 1'b0;
            letters_reg <= '0;
            len_reg     <= '0;
        end else if (consume) begin
            mode_reg    <= mode_next;
            acc_reg     <= acc_next;
            clamp_reg   <= clamp_next;
            letters_reg <= letters_next;
            len_reg     <= len_next;
        end
    end

endmodule

### rtl/etok_outbuf.sv
// ----------------------------------------------------------------------------
// etok_outbuf
// Two-slot result register: holds the tokens of one character and hands
// them out one word per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module etok_outbuf (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  etok_pkg::etok_push_t           push_in,
    output logic                           push_ok,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [3:0] token_kind, [34:4] number_value, [39:35] variable_letter,
    // [40] number_saturated, [47:41] zero
    output logic [etok_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast    // run_last
);
    import etok_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    token_t     slot0_reg, slot0_next;
    token_t     slot1_reg, slot1_next;
    logic       pop;

    assign m_tvalid = cnt_reg != 2'd0;
    assign pop      = m_tvalid && m_tready;
    assign push_ok  = cnt_reg == 2'd0 || (cnt_reg == 2'd1 && m_tready);
    assign m_tdata  = {7'd0, slot0_reg.sat, slot0_reg.letter, slot0_reg.value,
                       slot0_reg.kind};
    assign m_tlast  = slot0_reg.last;

    always_comb begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (push_in.push) begin
            cnt_next   = push_in.two ? 2'd2 : 2'd1;
            slot0_next = push_in.t0;
            slot1_next = push_in.t1;
        end else if (pop) begin
            // advance the second token to the head
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

### rtl/expression_tokenizer.sv
// ----------------------------------------------------------------------------
// expression_tokenizer
// Streaming lexer for arithmetic expressions, one character per word.
// ----------------------------------------------------------------------------
// Takes one character per cycle while the result register has room and
// emits tokens: numbers (saturating at 2^31-1), single-letter variables,
// sin/cos/tan or unknown words, and the operators + - * / ( ). A taken
// character is registered in the input register, its tokens in the
// two-slot result register. One that yields two tokens (a pending token
// plus an operator or a flushed token) fills both slots and holds the
// input while they drain. m_tlast marks the last token caused by a character.
module expression_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] ch
    input  logic        s_tlast,    // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] token_kind, [34:4] number_value, [39:35] variable_letter,
    // [40] number_saturated, [47:41] zero
    output logic [47:0] m_tdata,
    output logic        m_tlast     // run_last
);
    import etok_pkg::*;

    etok_push_t push;
    logic       push_ok;

    etok_lexer u_lexer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .push_ok  (push_ok),
        .push_out (push)
    );

    etok_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_in  (push),
        .push_ok  (push_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/etok_checker.sv
// ----------------------------------------------------------------------------
// etok_checker
// Port-level checks on the token stream of the expression tokenizer.
// ----------------------------------------------------------------------------
module etok_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);
    import etok_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3:0] <= KIND_TAN && m_tdata[47:41] == 7'd0)
        else $error("bad token kind or padding");

    a_number: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:0] != KIND_NUMBER |-> m_tdata[34:4] == 31'd0 && !m_tdata[40])
        else $error("number fields set on a non-number token");

    a_letter: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] == KIND_VARIABLE) ? m_tdata[39:35] <= 5'd25
                                                     : m_tdata[39:35] == 5'd0)
        else $error("bad variable letter");

endmodule

bind expression_tokenizer etok_checker u_etok_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
